// ----- rtl/kbf_pkg.sv -----
// shared types, constants and axis helpers for the kill button filter
package kbf_pkg;

   localparam int unsigned AXIS_W = 16;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned CFG_W = 16;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   localparam logic [CFG_W-1:0] DEBOUNCE_MS_RESET = 16'd25;
   localparam logic [CFG_W-1:0] DOUBLE_CLICK_MS_RESET = 16'd500;

   // register select taken from paddr bit 2
   localparam logic CSR_IDX_DEBOUNCE = 1'b0;
   localparam logic CSR_IDX_DOUBLE_CLICK = 1'b1;

   typedef logic [2:0][AXIS_W-1:0] axis3_type;

   typedef struct packed {
      logic [TIME_W-1:0]        now_ms;
      logic                     rot_kill_pressed;
      logic                     trans_kill_pressed;
      logic signed [AXIS_W-1:0] trans_x_in;
      logic signed [AXIS_W-1:0] trans_y_in;
      logic signed [AXIS_W-1:0] trans_z_in;
      logic signed [AXIS_W-1:0] rot_x_in;
      logic signed [AXIS_W-1:0] rot_y_in;
      logic signed [AXIS_W-1:0] rot_z_in;
   } req_data_type;

   typedef struct packed {
      logic signed [AXIS_W-1:0] trans_x_out;
      logic signed [AXIS_W-1:0] trans_y_out;
      logic signed [AXIS_W-1:0] trans_z_out;
      logic signed [AXIS_W-1:0] rot_x_out;
      logic signed [AXIS_W-1:0] rot_y_out;
      logic signed [AXIS_W-1:0] rot_z_out;
      logic                     rot_killed;
      logic                     trans_killed;
      logic                     rot_dominant_mode;
      logic                     trans_dominant_mode;
   } rsp_data_type;

   typedef struct packed {
      logic killed;
      logic dominant;
   } button_status_type;

   function automatic logic [AXIS_W:0] magnitude(logic [AXIS_W-1:0] v);
      logic [AXIS_W:0] ext;
      ext = {1'b0, v};
      return v[AXIS_W-1] ? (17'h10000 - ext) : ext;
   endfunction

   // keep only the largest magnitude axis, lowest axis wins ties
   function automatic axis3_type keep_dominant(axis3_type v);
      logic [AXIS_W:0] m0;
      logic [AXIS_W:0] m1;
      logic [AXIS_W:0] m2;
      logic [AXIS_W:0] best_mag;
      logic [1:0]      best;
      axis3_type       res;
      m0 = magnitude(v[0]);
      m1 = magnitude(v[1]);
      m2 = magnitude(v[2]);
      best = 2'd0;
      best_mag = m0;
      if (m1 > best_mag) begin
         best = 2'd1;
         best_mag = m1;
      end
      if (m2 > best_mag) begin
         best = 2'd2;
      end
      res = '0;
      case (best)
         2'd0: res[0] = v[0];
         2'd1: res[1] = v[1];
         default: res[2] = v[2];
      endcase
      return res;
   endfunction

endpackage

// ----- rtl/kbf_debounce.sv -----
// per button debounce, press timing and dominant mode toggle
module kbf_debounce import kbf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 raw,
   input  logic [TIME_W-1:0]    now_ms,
   input  logic [CFG_W-1:0]     debounce_ms,
   input  logic [CFG_W-1:0]     double_click_ms,
   output button_status_type    status
);

   logic              raw_level_ff, raw_level_in;
   logic              stable_level_ff, stable_level_in;
   logic              dominant_mode_ff, dominant_mode_in;
   logic [TIME_W-1:0] raw_change_time_ff, raw_change_time_in;
   logic [TIME_W-1:0] last_press_time_ff, last_press_time_in;
   logic [TIME_W-1:0] held_time;
   logic [TIME_W-1:0] since_press;
   logic              settle;

   always_comb begin
      raw_level_in = raw;
      raw_change_time_in = (raw != raw_level_ff) ? now_ms : raw_change_time_ff;
      held_time = now_ms - raw_change_time_in;
      since_press = now_ms - last_press_time_ff;
      settle = (stable_level_ff != raw) && (held_time >= TIME_W'(debounce_ms));
      stable_level_in = settle ? raw : stable_level_ff;
      dominant_mode_in = dominant_mode_ff;
      last_press_time_in = last_press_time_ff;
      if (settle && raw) begin
         if ((last_press_time_ff != '0) && (since_press <= TIME_W'(double_click_ms))) begin
            dominant_mode_in = ~dominant_mode_ff;
            last_press_time_in = '0;
         end else begin
            last_press_time_in = now_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_level_ff <= 1'b0;
         stable_level_ff <= 1'b0;
         dominant_mode_ff <= 1'b0;
         raw_change_time_ff <= '0;
         last_press_time_ff <= '0;
      end else if (step) begin
         raw_level_ff <= raw_level_in;
         stable_level_ff <= stable_level_in;
         dominant_mode_ff <= dominant_mode_in;
         raw_change_time_ff <= raw_change_time_in;
         last_press_time_ff <= last_press_time_in;
      end
   end

   assign status.killed = stable_level_in;
   assign status.dominant = dominant_mode_in;

endmodule

// ----- rtl/kbf_axis_filter.sv -----
// zeroes killed axis groups and applies dominant-only selection
module kbf_axis_filter import kbf_pkg::*; (
   input  req_data_type      sample,
   input  button_status_type rot_status,
   input  button_status_type trans_status,
   output rsp_data_type      result
);

   axis3_type trans_v;
   axis3_type rot_v;

   always_comb begin
      trans_v[0] = sample.trans_x_in;
      trans_v[1] = sample.trans_y_in;
      trans_v[2] = sample.trans_z_in;
      rot_v[0] = sample.rot_x_in;
      rot_v[1] = sample.rot_y_in;
      rot_v[2] = sample.rot_z_in;
      // rotation kill first, then translation kill
      if (rot_status.killed) begin
         rot_v = '0;
         if (rot_status.dominant) begin
            trans_v = keep_dominant(trans_v);
         end
      end
      if (trans_status.killed) begin
         trans_v = '0;
         if (trans_status.dominant) begin
            rot_v = keep_dominant(rot_v);
         end
      end
      result.trans_x_out = $signed(trans_v[0]);
      result.trans_y_out = $signed(trans_v[1]);
      result.trans_z_out = $signed(trans_v[2]);
      result.rot_x_out = $signed(rot_v[0]);
      result.rot_y_out = $signed(rot_v[1]);
      result.rot_z_out = $signed(rot_v[2]);
      result.rot_killed = rot_status.killed;
      result.trans_killed = trans_status.killed;
      result.rot_dominant_mode = rot_status.dominant;
      result.trans_dominant_mode = trans_status.dominant;
   end

endmodule

// ----- rtl/axis_kill_button_filter.sv -----
// top level: sample register, debounce and axis filter, result register, csr port
// rsp_valid rises when a sample moves from the sample register into the result register
// throughput: one transfer per cycle while rsp_ready is high; the result register frees when rsp_ready is high
// the button state updates as a sample moves from the sample register to the result register
// reset (synchronous) empties both registers, clears button state and loads
// debounce_ms = 25 and double_click_ms = 500
module axis_kill_button_filter import kbf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_data_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_data_type          rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic              in_valid_ff;
   req_data_type      in_data_ff;
   logic              out_valid_ff;
   rsp_data_type      out_data_ff;
   rsp_data_type      out_data_in;
   logic              advance;
   logic [CFG_W-1:0]  debounce_ms_ff;
   logic [CFG_W-1:0]  double_click_ms_ff;
   logic              csr_write;
   button_status_type rot_status;
   button_status_type trans_status;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      unique case (paddr[2])
         CSR_IDX_DEBOUNCE:     prdata = CSR_DATA_W'(debounce_ms_ff);
         CSR_IDX_DOUBLE_CLICK: prdata = CSR_DATA_W'(double_click_ms_ff);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff <= DEBOUNCE_MS_RESET;
         double_click_ms_ff <= DOUBLE_CLICK_MS_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            CSR_IDX_DEBOUNCE:     debounce_ms_ff <= pwdata[CFG_W-1:0];
            CSR_IDX_DOUBLE_CLICK: double_click_ms_ff <= pwdata[CFG_W-1:0];
            default:              debounce_ms_ff <= debounce_ms_ff;
         endcase
      end
   end

   kbf_debounce u_rot_debounce (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .raw             (in_data_ff.rot_kill_pressed),
      .now_ms          (in_data_ff.now_ms),
      .debounce_ms     (debounce_ms_ff),
      .double_click_ms (double_click_ms_ff),
      .status          (rot_status)
   );

   kbf_debounce u_trans_debounce (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .raw             (in_data_ff.trans_kill_pressed),
      .now_ms          (in_data_ff.now_ms),
      .debounce_ms     (debounce_ms_ff),
      .double_click_ms (double_click_ms_ff),
      .status          (trans_status)
   );

   kbf_axis_filter u_axis_filter (
      .sample       (in_data_ff),
      .rot_status   (rot_status),
      .trans_status (trans_status),
      .result       (out_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule
